FILE: rtl/pba_pkg.sv
// Shared types and constants for the page bitmap / share count allocator.
// No dependencies; used by the allocator top level and the testbench.
package pba_pkg;

	localparam int NUM_SEGMENTS  = 4;
	localparam int SEGMENT_PAGES = 1024;
	localparam int TOTAL_FRAMES  = NUM_SEGMENTS * SEGMENT_PAGES;
	localparam int FRAME_W       = $clog2(TOTAL_FRAMES);
	localparam int SEG_W         = $clog2(NUM_SEGMENTS);
	localparam int IDX_W         = $clog2(SEGMENT_PAGES);
	localparam int COUNT_W       = 13;
	localparam int SHARE_W       = 16;
	localparam int FREE_W        = IDX_W + 1;
	localparam int CFG_DATA_W    = 13;

	localparam logic [SHARE_W-1:0] SHARE_MAX = 16'hFFFF;

	typedef enum logic [1:0] {
		OP_ALLOC   = 2'd0,
		OP_FREE    = 2'd1,
		OP_RETAIN  = 2'd2,
		OP_RELEASE = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_BAD_ARG   = 3'd1,
		ST_NO_ROOM   = 3'd2,
		ST_OUTSIDE   = 3'd3,
		ST_NOT_HELD  = 3'd4,
		ST_SATURATED = 3'd5
	} status_t;

	typedef enum logic {
		CFG_SEGMENTS_PRESENT   = 1'b0,
		CFG_DIRECT_LIMIT_PAGES = 1'b1
	} cfg_index_t;

	typedef struct packed {
		logic [1:0]         operation;
		logic [FRAME_W-1:0] page_frame;
		logic [COUNT_W-1:0] page_count;
	} in_word_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [FRAME_W-1:0] granted_frame;
		logic               freed_unheld;
	} out_word_t;

endpackage

FILE: rtl/pba_ram.sv
// Generic single-port-write, single-port-read synchronous RAM, registered read.
// No dependencies.
module pba_ram #(
	parameter int DEPTH = 4096,
	parameter int WIDTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/page_bitmap_refcount_allocator.sv
// Top level of the page frame allocator: sequencer, segment counts, output word.
// Depends on pba_pkg and pba_ram (per-page share counts; a page is used when nonzero).
//
//  channel | signals                        | direction
//  --------+--------------------------------+----------
//  in      | in_valid, in_stall, in_word    | request word in
//  out     | out_valid, out_stall, out_word | result word out
//  cfg     | cfg_we, cfg_index, cfg_data    | register write in
//
// After reset the share store is cleared one entry a cycle, with in_stall high throughout.
// Retain/release: read then write of the one page. Free of n pages: read then write per page.
// Allocate: segments are scanned in turn, one page a cycle from the share store, then the
// run is marked page by page; the scan rate is set by the single read port of the store.
// A request is taken while the previous result still waits in the output register.
module page_bitmap_refcount_allocator (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  pba_pkg::in_word_t                in_word,
	output logic                             out_valid,
	input  logic                             out_stall,
	output pba_pkg::out_word_t               out_word,
	input  logic                             cfg_we,
	input  logic                             cfg_index,
	input  logic [pba_pkg::CFG_DATA_W-1:0]   cfg_data
);

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_SEG, S_SCAN, S_MARK, S_FRD, S_FWR, S_PRD, S_PWR, S_DONE
	} state_t;

	localparam int FW = pba_pkg::FRAME_W;
	localparam int SW = pba_pkg::SEG_W;
	localparam int IW = pba_pkg::IDX_W;
	localparam int CW = pba_pkg::COUNT_W;
	localparam int HW = pba_pkg::SHARE_W;
	localparam int NW = pba_pkg::FREE_W;

	state_t                  state_q;
	logic [pba_pkg::NUM_SEGMENTS-1:0] present_q;
	logic [CW-1:0]           limit_q;
	logic [NW-1:0]           free_cnt_q [pba_pkg::NUM_SEGMENTS];
	logic [1:0]              op_q;
	logic [FW-1:0]           frame_q;
	logic [CW-1:0]           count_q;
	logic [SW-1:0]           seg_q;
	logic [CW-1:0]           seg_lim_q;
	logic [NW-1:0]           issue_q;
	logic [NW-1:0]           run_q;
	logic [IW-1:0]           start_q;
	logic [CW-1:0]           k_q;
	logic                    rv_s1;
	logic [IW-1:0]           ri_s1;
	logic [FW-1:0]           clr_q;
	pba_pkg::status_t        status_q;
	logic [FW-1:0]           granted_q;
	logic                    unheld_q;
	logic                    out_valid_q;
	pba_pkg::out_word_t      out_word_q;

	logic          mem_we;
	logic [FW-1:0] mem_waddr, mem_raddr;
	logic [HW-1:0] mem_wdata, mem_rdata;

	pba_ram #(.DEPTH(pba_pkg::TOTAL_FRAMES), .WIDTH(HW)) u_shares (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// decode of the current request and segment
	logic [FW-1:0] base;
	logic [SW-1:0] in_seg;
	logic [CW-1:0] base13, lim_raw, lim_clip;
	logic          seg_ok, last_seg;
	logic          pg_free;
	logic [NW-1:0] new_run;
	logic [IW-1:0] new_start;
	logic [CW:0]   run_end;
	logic [FW-1:0] mark_addr, walk_addr;
	logic [CW:0]   free_end;

	assign base      = {seg_q, {IW{1'b0}}};
	assign in_seg    = in_word.page_frame[FW-1 -: SW];
	assign base13    = CW'(base);
	assign lim_raw   = limit_q - base13;
	assign lim_clip  = (lim_raw > CW'(pba_pkg::SEGMENT_PAGES)) ? CW'(pba_pkg::SEGMENT_PAGES)
		: lim_raw;
	assign seg_ok    = present_q[seg_q] && (CW'(free_cnt_q[seg_q]) >= count_q)
		&& (base13 < limit_q) && (lim_clip >= count_q);
	assign last_seg  = seg_q == SW'(pba_pkg::NUM_SEGMENTS - 1);
	assign pg_free   = mem_rdata == '0;
	assign new_run   = pg_free ? run_q + NW'(1) : '0;
	assign new_start = (pg_free && run_q == '0) ? ri_s1 : start_q;
	assign run_end   = (CW+1)'(new_start) + (CW+1)'(count_q);
	assign mark_addr = base + FW'(start_q) + k_q[FW-1:0];
	assign walk_addr = frame_q + k_q[FW-1:0];
	assign free_end  = (CW+1)'(in_word.page_frame[IW-1:0]) + (CW+1)'(in_word.page_count);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = walk_addr;
		mem_wdata = '0;
		mem_raddr = walk_addr;
		case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
			end
			S_SCAN: mem_raddr = base | FW'(issue_q[IW-1:0]);
			S_MARK: begin
				mem_we    = 1'b1;
				mem_waddr = mark_addr;
				mem_wdata = HW'(1);
			end
			S_FWR: begin
				mem_we    = !pg_free;
				mem_wdata = (mem_rdata > HW'(1)) ? mem_rdata - HW'(1) : '0;
			end
			S_PWR: begin
				if (op_q == pba_pkg::OP_RETAIN) begin
					mem_we    = !pg_free && mem_rdata != pba_pkg::SHARE_MAX;
					mem_wdata = mem_rdata + HW'(1);
				end else begin
					mem_we    = !pg_free;
					mem_wdata = mem_rdata - HW'(1);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			present_q   <= '1;
			limit_q     <= CW'(pba_pkg::TOTAL_FRAMES);
			for (int s = 0; s < pba_pkg::NUM_SEGMENTS; s++)
				free_cnt_q[s] <= NW'(pba_pkg::SEGMENT_PAGES);
			seg_q       <= '0;
			clr_q       <= '0;
			rv_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					pba_pkg::CFG_SEGMENTS_PRESENT:
						present_q <= cfg_data[pba_pkg::NUM_SEGMENTS-1:0];
					pba_pkg::CFG_DIRECT_LIMIT_PAGES: limit_q <= cfg_data[CW-1:0];
					default: ;
				endcase
			end
			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;

			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + FW'(1);
					if (clr_q == FW'(pba_pkg::TOTAL_FRAMES - 1))
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_valid) begin
						op_q      <= in_word.operation;
						frame_q   <= in_word.page_frame;
						count_q   <= in_word.page_count;
						k_q       <= '0;
						granted_q <= '0;
						unheld_q  <= 1'b0;
						status_q  <= pba_pkg::ST_OK;
						seg_q     <= in_seg;
						state_q   <= S_DONE;
						case (pba_pkg::op_t'(in_word.operation))
							pba_pkg::OP_ALLOC: begin
								seg_q <= '0;
								if (in_word.page_count == '0)
									status_q <= pba_pkg::ST_BAD_ARG;
								else
									state_q <= S_SEG;
							end
							pba_pkg::OP_FREE: begin
								if (in_word.page_frame == '0 || in_word.page_count == '0)
									status_q <= pba_pkg::ST_BAD_ARG;
								else if (!present_q[in_seg]
									|| free_end > (CW+1)'(pba_pkg::SEGMENT_PAGES))
									status_q <= pba_pkg::ST_OUTSIDE;
								else
									state_q <= S_FRD;
							end
							default: begin
								if (in_word.page_frame == '0)
									status_q <= pba_pkg::ST_BAD_ARG;
								else if (!present_q[in_seg])
									status_q <= pba_pkg::ST_OUTSIDE;
								else
									state_q <= S_PRD;
							end
						endcase
					end
				end
				S_SEG: begin
					if (seg_ok) begin
						seg_lim_q <= lim_clip;
						issue_q   <= '0;
						run_q     <= '0;
						start_q   <= '0;
						rv_s1     <= 1'b0;
						state_q   <= S_SCAN;
					end else if (last_seg) begin
						status_q <= pba_pkg::ST_NO_ROOM;
						state_q  <= S_DONE;
					end else begin
						seg_q <= seg_q + SW'(1);
					end
				end
				S_SCAN: begin
					// reads run one page ahead of the run tracking
					if (issue_q < NW'(pba_pkg::SEGMENT_PAGES)) begin
						issue_q <= issue_q + NW'(1);
						ri_s1   <= issue_q[IW-1:0];
						rv_s1   <= 1'b1;
					end else begin
						rv_s1 <= 1'b0;
					end
					if (rv_s1) begin
						run_q   <= new_run;
						start_q <= new_start;
						if (pg_free && CW'(new_run) >= count_q) begin
							rv_s1 <= 1'b0;
							if (run_end <= (CW+1)'(seg_lim_q)) begin
								state_q <= S_MARK;
							end else if (last_seg) begin
								status_q <= pba_pkg::ST_NO_ROOM;
								state_q  <= S_DONE;
							end else begin
								seg_q   <= seg_q + SW'(1);
								state_q <= S_SEG;
							end
						end else if (ri_s1 == IW'(pba_pkg::SEGMENT_PAGES - 1)) begin
							rv_s1 <= 1'b0;
							if (last_seg) begin
								status_q <= pba_pkg::ST_NO_ROOM;
								state_q  <= S_DONE;
							end else begin
								seg_q   <= seg_q + SW'(1);
								state_q <= S_SEG;
							end
						end
					end
				end
				S_MARK: begin
					if (k_q == count_q - CW'(1)) begin
						free_cnt_q[seg_q] <= free_cnt_q[seg_q] - count_q[NW-1:0];
						granted_q         <= base + FW'(start_q);
						state_q           <= S_DONE;
					end else begin
						k_q <= k_q + CW'(1);
					end
				end
				S_FRD: state_q <= S_FWR;
				S_FWR: begin
					if (pg_free)
						unheld_q <= 1'b1;
					else if (mem_rdata == HW'(1))
						free_cnt_q[seg_q] <= free_cnt_q[seg_q] + NW'(1);
					if (k_q == count_q - CW'(1)) begin
						state_q <= S_DONE;
					end else begin
						k_q     <= k_q + CW'(1);
						state_q <= S_FRD;
					end
				end
				S_PRD: state_q <= S_PWR;
				S_PWR: begin
					if (pg_free)
						status_q <= pba_pkg::ST_NOT_HELD;
					else if (op_q == pba_pkg::OP_RETAIN && mem_rdata == pba_pkg::SHARE_MAX)
						status_q <= pba_pkg::ST_SATURATED;
					else if (op_q == pba_pkg::OP_RELEASE && mem_rdata == HW'(1))
						free_cnt_q[seg_q] <= free_cnt_q[seg_q] + NW'(1);
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q                <= 1'b1;
						out_word_q.status          <= status_q;
						out_word_q.granted_frame   <= granted_q;
						out_word_q.freed_unheld    <= unheld_q;
						state_q                    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall  = state_q != S_IDLE;
	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLEAR |-> in_stall)
		else $error("request taken during clearing pass");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !mem_we)
		else $error("share store written while idle");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_DONE)
		else $error("result word raised outside completion");

	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		free_cnt_q[seg_q] <= NW'(pba_pkg::SEGMENT_PAGES))
		else $error("segment free count above segment size");

endmodule

FILE: verif/page_bitmap_refcount_allocator_tb.sv
// Self-checking testbench for the page frame allocator with per-page share counts.
// Depends on rtl/pba_pkg.sv and the allocator top level; a local model predicts each result word.
`timescale 1ns / 100ps

module page_bitmap_refcount_allocator_tb;
	import pba_pkg::*;

	localparam int WATCHDOG_CYCLES = 60000;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	in_word_t           in_word;
	logic               out_valid;
	logic               out_stall;
	out_word_t          out_word;
	logic               cfg_we;
	logic               cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	page_bitmap_refcount_allocator u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// allocator model state
	bit              mdl_used   [TOTAL_FRAMES];
	logic [15:0]     mdl_shares [TOTAL_FRAMES];
	int              mdl_seg_free [NUM_SEGMENTS];
	logic [3:0]      mdl_present;
	int              mdl_limit;

	out_word_t       pending_results [$];
	int              run_start [$];
	int              run_len   [$];
	int              idle_pct;
	int              stall_pct;
	int              mismatches;
	int              idle_count;

	function automatic bit seg_present(int s);
		return (s < NUM_SEGMENTS) && mdl_present[s];
	endfunction

	function automatic status_t model_alloc(int count, output int granted);
		int base, lim, run, start;
		bit found;
		granted = 0;
		for (int s = 0; s < NUM_SEGMENTS; s++) begin
			base = s * SEGMENT_PAGES;
			if (!seg_present(s) || mdl_seg_free[s] < count) continue;
			if (base >= mdl_limit) continue;
			lim = mdl_limit - base;
			if (lim > SEGMENT_PAGES) lim = SEGMENT_PAGES;
			if (lim < count) continue;
			run = 0;
			start = 0;
			found = 0;
			for (int i = 0; i < SEGMENT_PAGES; i++) begin
				if (!mdl_used[base + i]) begin
					if (run == 0) start = i;
					run++;
					if (run >= count) begin
						found = 1;
						break;
					end
				end else begin
					run = 0;
				end
			end
			if (!found || start + count > lim) continue;
			for (int i = 0; i < count; i++) begin
				mdl_used[base + start + i] = 1;
				mdl_shares[base + start + i] = 16'd1;
			end
			mdl_seg_free[s] -= count;
			granted = base + start;
			return ST_OK;
		end
		return ST_NO_ROOM;
	endfunction

	function automatic out_word_t predict_result(in_word_t w);
		out_word_t r;
		int frame, count, s, g, f;
		frame = w.page_frame;
		count = w.page_count;
		s = frame / SEGMENT_PAGES;
		r = '0;
		r.status = ST_OK;
		case (op_t'(w.operation))
			OP_ALLOC: begin
				if (count == 0) r.status = ST_BAD_ARG;
				else begin
					r.status = model_alloc(count, g);
					r.granted_frame = FRAME_W'(g);
				end
			end
			OP_FREE: begin
				if (frame == 0 || count == 0) r.status = ST_BAD_ARG;
				else if (!seg_present(s)) r.status = ST_OUTSIDE;
				else if (frame - s * SEGMENT_PAGES + count > SEGMENT_PAGES) r.status = ST_OUTSIDE;
				else begin
					for (int i = 0; i < count; i++) begin
						f = frame + i;
						if (!mdl_used[f]) r.freed_unheld = 1'b1;
						else if (mdl_shares[f] > 16'd1) mdl_shares[f]--;
						else begin
							mdl_used[f] = 0;
							mdl_shares[f] = '0;
							mdl_seg_free[s]++;
						end
					end
				end
			end
			OP_RETAIN: begin
				if (frame == 0) r.status = ST_BAD_ARG;
				else if (!seg_present(s)) r.status = ST_OUTSIDE;
				else if (mdl_shares[frame] == 0) r.status = ST_NOT_HELD;
				else if (mdl_shares[frame] == SHARE_MAX) r.status = ST_SATURATED;
				else mdl_shares[frame]++;
			end
			default: begin
				if (frame == 0) r.status = ST_BAD_ARG;
				else if (!seg_present(s)) r.status = ST_OUTSIDE;
				else if (mdl_shares[frame] == 0) r.status = ST_NOT_HELD;
				else begin
					mdl_shares[frame]--;
					if (mdl_shares[frame] == 0) begin
						mdl_used[frame] = 0;
						mdl_seg_free[s]++;
					end
				end
			end
		endcase
		return r;
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// result checker, receiver stall and watchdog
	always @(posedge clk) begin
		out_word_t want;
		bit moved;
		moved = (in_valid && !in_stall) || cfg_we;
		out_stall <= ($urandom_range(99) < stall_pct);
		if (arst_n && out_valid && !out_stall) begin
			moved = 1;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word %p", out_word);
			end else begin
				want = pending_results.pop_front();
				if (out_word.status !== want.status || out_word.granted_frame !== want.granted_frame
						|| out_word.freed_unheld !== want.freed_unheld) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p, got %p", want, out_word);
				end
			end
		end
		idle_count = moved ? 0 : idle_count + 1;
		if (idle_count >= WATCHDOG_CYCLES) begin
			$display("[page_bitmap_refcount_allocator] ERROR");
			$finish;
		end
	end

	task automatic send_word(input op_t op, input int frame, input int count,
			output out_word_t res);
		in_word_t w;
		w.operation  = op;
		w.page_frame = frame[FRAME_W-1:0];
		w.page_count = count[COUNT_W-1:0];
		if ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		in_valid <= 1'b1;
		in_word  <= w;
		do @(posedge clk); while (in_stall);
		res = predict_result(w);
		pending_results.push_back(res);
		if (op == OP_ALLOC && res.status == ST_OK) begin
			run_start.push_back(res.granted_frame);
			run_len.push_back(count);
			if (run_start.size() > 64) begin
				void'(run_start.pop_front());
				void'(run_len.pop_front());
			end
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_index_t idx, input int value);
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value[CFG_DATA_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_SEGMENTS_PRESENT) mdl_present = value[3:0];
		else mdl_limit = value[12:0];
	endtask

	task automatic test_argument_checks();
		out_word_t r;
		send_word(OP_ALLOC, 0, 0, r);
		send_word(OP_ALLOC, 4095, 1, r);       // lowest run grants frame zero
		send_word(OP_ALLOC, 0, 4, r);
		send_word(OP_FREE, 0, 1, r);
		send_word(OP_FREE, 5, 0, r);
		send_word(OP_RETAIN, 0, 0, r);
		send_word(OP_RELEASE, 0, 0, r);
		send_word(OP_RETAIN, 900, 0, r);       // not held
		send_word(OP_RELEASE, 901, 0, r);
		send_word(OP_FREE, 1, 8, r);           // covers some already-free pages
		send_word(OP_FREE, 1000, 100, r);      // leaves the segment
		send_word(OP_ALLOC, 0, 4096, r);       // larger than a segment
		send_word(OP_ALLOC, 0, 1024, r);
		send_word(OP_FREE, 1024, 4096, r);
		send_word(OP_FREE, 1024, 1024, r);
		send_word(OP_RETAIN, 4095, 8191, r);
		send_word(OP_RELEASE, 4095, 0, r);
	endtask

	task automatic test_segments_and_limit();
		out_word_t r;
		write_reg(CFG_SEGMENTS_PRESENT, 0);
		send_word(OP_ALLOC, 0, 1, r);
		send_word(OP_FREE, 2048, 1, r);
		send_word(OP_RETAIN, 3000, 0, r);
		write_reg(CFG_SEGMENTS_PRESENT, 4'b1010);
		send_word(OP_ALLOC, 0, 3, r);
		send_word(OP_RELEASE, 1, 0, r);
		write_reg(CFG_DIRECT_LIMIT_PAGES, 0);
		send_word(OP_ALLOC, 0, 1, r);
		write_reg(CFG_DIRECT_LIMIT_PAGES, 1030);
		send_word(OP_ALLOC, 0, 8, r);
		write_reg(CFG_SEGMENTS_PRESENT, 15);
		write_reg(CFG_DIRECT_LIMIT_PAGES, 4096);
	endtask

	task automatic test_share_counts();
		out_word_t r;
		int page;
		send_word(OP_ALLOC, 0, 1, r);
		page = r.granted_frame;
		for (int i = 0; i < 16; i++)
			send_word(OP_RETAIN, page, 0, r);
		send_word(OP_FREE, page, 1, r);        // drops a single share
		for (int i = 0; i < 17; i++)
			send_word(OP_RELEASE, page, 0, r); // last one finds the page free
	endtask

	task automatic test_random_traffic(input int items);
		out_word_t r;
		int k, pick, frame, count;
		for (int n = 0; n < items; n++) begin
			pick = $urandom_range(99);
			k = run_start.size();
			if (pick < 35) begin
				count = ($urandom_range(49) == 0) ? $urandom_range(8191) : $urandom_range(16, 1);
				send_word(OP_ALLOC, $urandom_range(4095), count, r);
			end else if (pick < 60 && k > 0) begin
				pick = $urandom_range(k - 1);
				frame = run_start[pick];
				count = run_len[pick];
				run_start.delete(pick);
				run_len.delete(pick);
				send_word(OP_FREE, frame, count, r);
			end else if (pick < 85 && k > 0) begin
				pick = $urandom_range(k - 1);
				frame = run_start[pick] + $urandom_range(run_len[pick] - 1);
				send_word($urandom_range(1) ? OP_RETAIN : OP_RELEASE, frame,
					$urandom_range(8191), r);
			end else begin
				count = $urandom_range(3) == 0 ? $urandom_range(8191) : $urandom_range(32);
				send_word(op_t'($urandom_range(3)), $urandom_range(4095), count, r);
			end
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_word   = '0;
		out_stall = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = CFG_SEGMENTS_PRESENT;
		cfg_data  = '0;
		idle_pct  = 0;
		stall_pct = 0;
		mismatches = 0;
		idle_count = 0;
		for (int i = 0; i < TOTAL_FRAMES; i++) begin
			mdl_used[i]   = 0;
			mdl_shares[i] = '0;
		end
		for (int s = 0; s < NUM_SEGMENTS; s++) mdl_seg_free[s] = SEGMENT_PAGES;
		mdl_present = 4'd15;
		mdl_limit   = 4096;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		test_argument_checks();
		test_segments_and_limit();
		test_share_counts();

		test_random_traffic(320);
		write_reg(CFG_SEGMENTS_PRESENT, 4'b0110);
		write_reg(CFG_DIRECT_LIMIT_PAGES, 2500);
		idle_pct = 88;
		test_random_traffic(300);
		write_reg(CFG_SEGMENTS_PRESENT, 4'b1001);
		write_reg(CFG_DIRECT_LIMIT_PAGES, 4096);
		idle_pct  = 0;
		stall_pct = 88;
		test_random_traffic(300);
		write_reg(CFG_SEGMENTS_PRESENT, 15);
		write_reg(CFG_DIRECT_LIMIT_PAGES, 3000);
		idle_pct  = 31;
		stall_pct = 31;
		test_random_traffic(330);

		drain();
		if (mismatches == 0)
			$display("[page_bitmap_refcount_allocator] OK");
		else
			$display("[page_bitmap_refcount_allocator] ERROR");
		$finish;
	end

endmodule
